[hw/rtl/haar2d_pkg.sv]
// Shared types, codes and the band rounding function for the 2D Haar block.
// No dependencies; every other file of the block refers to it by scoped names.

package haar2d_pkg;

   // Field widths fixed by the interface
   localparam int PIX_W   = 8;
   localparam int COORD_W = 8;
   localparam int CFG_W   = 9;

   // Size registers come out of reset at 256
   localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

   // Register indexes on the CSR port (paddr bit 2)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Band codes, also the emission order
   localparam logic [1:0] BAND_LL = 2'd0;
   localparam logic [1:0] BAND_HL = 2'd1;
   localparam logic [1:0] BAND_LH = 2'd2;
   localparam logic [1:0] BAND_HH = 2'd3;

   // Block queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One complete 2x2 block with its destination coordinates
   typedef struct packed {
      logic [PIX_W-1:0]   a;
      logic [PIX_W-1:0]   b;
      logic [PIX_W-1:0]   c;
      logic [PIX_W-1:0]   d;
      logic [COORD_W-1:0] row_top;
      logic [COORD_W-1:0] row_bot;
      logic [COORD_W-1:0] col_left;
      logic [COORD_W-1:0] col_right;
      logic               frame_end;
   } block_type;

   // Scale a band sum (LL by 1/4, HL and LH by 1/2, HH by 1), round half
   // to even, clamp to 0..255. Non-positive sums always give zero.
   function automatic logic [PIX_W-1:0] round_clamp(input logic signed [10:0] sum,
                                                     input logic [1:0] band);
      logic [9:0] u;
      logic [9:0] q;
      logic       up;
      u = sum[9:0];
      case (band)
         BAND_LL: begin
            q  = {2'b00, u[9:2]};
            up = u[1] & (u[0] | u[2]);
         end
         BAND_HL, BAND_LH: begin
            q  = {1'b0, u[9:1]};
            up = u[0] & u[1];
         end
         default: begin
            // HH is not scaled
            q  = u;
            up = 1'b0;
         end
      endcase
      q = q + {9'b0, up};
      if (sum <= 11'sd0) begin
         return '0;
      end else if (q > 10'd255) begin
         return 8'd255;
      end else begin
         return q[PIX_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/haar2d_front.sv]
// Front end: pixel position counters, upper line store and block assembly.
// Depends on haar2d_pkg for the block type and field widths.

module haar2d_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [haar2d_pkg::CFG_W-1:0]   width_cfg,
   input  logic [haar2d_pkg::CFG_W-1:0]   height_cfg,
   input  logic                           pix_accept,
   input  logic [haar2d_pkg::PIX_W-1:0]   pixel,
   input  logic                           frame_start,
   output logic                           blk_push,
   output haar2d_pkg::block_type          blk
);

   // Counter and size widths
   localparam int CW  = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
   localparam int RW  = ($clog2(MAX_HEIGHT) > 2) ? $clog2(MAX_HEIGHT) : 2;
   localparam int WSW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
   localparam int HSW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
   localparam int MEM_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
   localparam int AW = CW - 1;
   localparam logic [WSW-1:0] W_CAP = WSW'((MAX_WIDTH / 2) * 2);
   localparam logic [HSW-1:0] H_CAP = HSW'((MAX_HEIGHT / 2) * 2);

   logic [CW-1:0]  col_ff, col_in, col_cur;
   logic [RW-1:0]  row_ff, row_in, row_cur;
   logic [WSW-1:0] w_raw, w_eff, colx, col_inc;
   logic [HSW-1:0] h_raw, h_eff, rowx, row_inc;
   logic [AW-1:0]  addr;
   logic           col_wrap, row_wrap;

   logic [haar2d_pkg::PIX_W-1:0] even_mem [MEM_DEPTH];
   logic [haar2d_pkg::PIX_W-1:0] odd_mem  [MEM_DEPTH];
   logic [haar2d_pkg::PIX_W-1:0] a_ff, b_ff, c_ff;

   // Effective sizes: drop the low bit, saturate to 2..max
   always_comb begin
      w_raw = WSW'({width_cfg[haar2d_pkg::CFG_W-1:1], 1'b0});
      h_raw = HSW'({height_cfg[haar2d_pkg::CFG_W-1:1], 1'b0});
      if (w_raw < WSW'(2)) begin
         w_eff = WSW'(2);
      end else if (w_raw > W_CAP) begin
         w_eff = W_CAP;
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < HSW'(2)) begin
         h_eff = HSW'(2);
      end else if (h_raw > H_CAP) begin
         h_eff = H_CAP;
      end else begin
         h_eff = h_raw;
      end
   end

   // Position of this pixel, then the position of the next one
   always_comb begin
      col_cur = (frame_start || WSW'(col_ff) >= w_eff) ? '0 : col_ff;
      row_cur = (frame_start || HSW'(row_ff) >= h_eff) ? '0 : row_ff;
      colx    = WSW'(col_cur);
      rowx    = HSW'(row_cur);
      col_inc = colx + WSW'(1);
      row_inc = rowx + HSW'(1);
      col_wrap = col_inc >= w_eff;
      row_wrap = row_inc >= h_eff;
      col_in = col_wrap ? '0 : col_inc[CW-1:0];
      if (!col_wrap) begin
         row_in = row_cur;
      end else if (row_wrap) begin
         row_in = '0;
      end else begin
         row_in = row_inc[RW-1:0];
      end
      addr = col_cur[CW-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Upper row store, split by column parity; written on even rows
   always_ff @(posedge clock) begin
      if (pix_accept && !row_cur[0]) begin
         if (!col_cur[0]) begin
            even_mem[addr] <= pixel;
         end else begin
            odd_mem[addr] <= pixel;
         end
      end
   end

   // On the lower-left pixel, fetch a and b and keep c
   always_ff @(posedge clock) begin
      if (pix_accept && row_cur[0] && !col_cur[0]) begin
         a_ff <= even_mem[addr];
         b_ff <= odd_mem[addr];
         c_ff <= pixel;
      end
   end

   // Lower-right pixel completes a block
   always_comb begin
      blk_push      = pix_accept && row_cur[0] && col_cur[0];
      blk.a         = a_ff;
      blk.b         = b_ff;
      blk.c         = c_ff;
      blk.d         = pixel;
      blk.row_top   = rowx[8:1];
      blk.row_bot   = rowx[8:1] + h_eff[8:1];
      blk.col_left  = colx[8:1];
      blk.col_right = colx[8:1] + w_eff[8:1];
      blk.frame_end = col_wrap && row_wrap;
   end

endmodule

[hw/rtl/haar2d_queue.sv]
// Short block queue between the front end and the band sequencer.
// Depends on haar2d_pkg for the block type and the queue depth.

module haar2d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  haar2d_pkg::block_type wr_data,
   output logic                  full,
   input  logic                  pop,
   output haar2d_pkg::block_type rd_data,
   output logic                  empty
);

   haar2d_pkg::block_type ent_ff [haar2d_pkg::QUEUE_DEPTH];
   logic [haar2d_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [haar2d_pkg::QCNT_W-1:0] count_ff;

   assign full    = count_ff == haar2d_pkg::QCNT_W'(haar2d_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = ent_ff[rd_ptr_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[hw/rtl/haar2d_back.sv]
// Back end: walks the four bands of the head block and drives the result register.
// Depends on haar2d_pkg for the block type, band codes and round_clamp.

module haar2d_back (
   input  logic                                clock,
   input  logic                                reset,
   input  haar2d_pkg::block_type               blk,
   input  logic                                blk_valid,
   output logic                                blk_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [haar2d_pkg::PIX_W-1:0]        rsp_coefficient,
   output logic [haar2d_pkg::COORD_W-1:0]      rsp_out_row,
   output logic [haar2d_pkg::COORD_W-1:0]      rsp_out_col,
   output logic [1:0]                          rsp_band,
   output logic                                rsp_last_of_block,
   output logic                                rsp_frame_end
);

   logic [1:0]                       phase_ff;
   logic                             vld_ff;
   logic [haar2d_pkg::PIX_W-1:0]     coef_ff, coef_in;
   logic [haar2d_pkg::COORD_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [1:0]                       band_ff;
   logic                             last_ff, fend_ff;
   logic                             load;
   logic signed [10:0]               sa, sb, sc, sd, sum;

   // Output register takes a new beat when empty or being drained
   assign load    = blk_valid && (!vld_ff || rsp_pop);
   assign blk_pop = load && (phase_ff == haar2d_pkg::BAND_HH);

   // Band sum, coordinates for the current phase
   always_comb begin
      sa = $signed({3'b000, blk.a});
      sb = $signed({3'b000, blk.b});
      sc = $signed({3'b000, blk.c});
      sd = $signed({3'b000, blk.d});
      case (phase_ff)
         haar2d_pkg::BAND_LL: begin
            sum    = sa + sb + sc + sd;
            row_in = blk.row_top;
            col_in = blk.col_left;
         end
         haar2d_pkg::BAND_HL: begin
            sum    = sa - sb + sc - sd;
            row_in = blk.row_top;
            col_in = blk.col_right;
         end
         haar2d_pkg::BAND_LH: begin
            sum    = sa + sb - sc - sd;
            row_in = blk.row_bot;
            col_in = blk.col_left;
         end
         default: begin
            sum    = sa - sb - sc + sd;
            row_in = blk.row_bot;
            col_in = blk.col_right;
         end
      endcase
      coef_in = haar2d_pkg::round_clamp(sum, phase_ff);
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         coef_ff <= coef_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         band_ff <= phase_ff;
         last_ff <= phase_ff == haar2d_pkg::BAND_HH;
         fend_ff <= (phase_ff == haar2d_pkg::BAND_HH) && blk.frame_end;
      end
   end

   // Phase and valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= haar2d_pkg::BAND_LL;
         vld_ff   <= 1'b0;
      end else begin
         if (load) begin
            phase_ff <= phase_ff + 2'd1;
            vld_ff   <= 1'b1;
         end else if (rsp_pop) begin
            vld_ff   <= 1'b0;
         end
      end
   end

   assign rsp_empty         = !vld_ff;
   assign rsp_coefficient   = coef_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_band          = band_ff;
   assign rsp_last_of_block = last_ff;
   assign rsp_frame_end     = fend_ff;

endmodule

[hw/rtl/haar_2d_wavelet_one_level.sv]
// Top level of the one-level 2D Haar transform: size registers and block wiring.
// Depends on haar2d_pkg, haar2d_front, haar2d_queue and haar2d_back.
//
// Pixels enter in raster order on the req_ queue port (push/full), one beat per
// pixel; req_frame_start on a beat restarts the row and column counters.
// Results leave on the rsp_ queue port (empty/pop): four beats per 2x2 block,
// LL, HL, LH, HH, each with its quadrant-layout row and column.
// The LL beat is written into the block queue when the lower-right pixel of its
// block is taken, and then loaded into the result register on the rsp_ port;
// HL, LH and HH follow one per cycle when popped.
// Throughput: one pixel per cycle while the block queue has room. On lower rows
// every second pixel yields four result beats, so once the four-entry block
// queue fills, the result port sets the pace.
// A stalled result port fills the block queue and then raises req_full.
// Reset clears counters, queue and result register and sets both size
// registers to 256; the line store is not cleared and needs no clearing pass.
// The CSR port holds image_width at offset 0 and image_height at offset 4;
// write them only while the block is idle.

module haar_2d_wavelet_one_level #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [haar2d_pkg::PIX_W-1:0]      req_pixel,
   input  logic                              req_frame_start,
   // results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [haar2d_pkg::PIX_W-1:0]      rsp_coefficient,
   output logic [haar2d_pkg::COORD_W-1:0]    rsp_out_row,
   output logic [haar2d_pkg::COORD_W-1:0]    rsp_out_col,
   output logic [1:0]                        rsp_band,
   output logic                              rsp_last_of_block,
   output logic                              rsp_frame_end,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [haar2d_pkg::CFG_W-1:0] width_ff, height_ff;
   logic                         csr_wr, pix_accept, blk_push, q_full;
   logic                         q_empty, q_pop;
   haar2d_pkg::block_type        blk_wr, blk_rd;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= haar2d_pkg::SIZE_RESET;
         height_ff <= haar2d_pkg::SIZE_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == haar2d_pkg::REG_WIDTH) begin
            width_ff <= csr_pwdata[haar2d_pkg::CFG_W-1:0];
         end else begin
            height_ff <= csr_pwdata[haar2d_pkg::CFG_W-1:0];
         end
      end
   end

   // Read mux; unaligned offsets read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == haar2d_pkg::REG_WIDTH) begin
            csr_prdata = 32'(width_ff);
         end else begin
            csr_prdata = 32'(height_ff);
         end
      end
   end

   // Input beat is taken whenever the block queue has room
   assign req_full   = q_full;
   assign pix_accept = req_push && !q_full;

   haar2d_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .width_cfg   (width_ff),
      .height_cfg  (height_ff),
      .pix_accept  (pix_accept),
      .pixel       (req_pixel),
      .frame_start (req_frame_start),
      .blk_push    (blk_push),
      .blk         (blk_wr)
   );

   haar2d_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (blk_push),
      .wr_data (blk_wr),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (blk_rd),
      .empty   (q_empty)
   );

   haar2d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .blk               (blk_rd),
      .blk_valid         (!q_empty),
      .blk_pop           (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_coefficient   (rsp_coefficient),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_band          (rsp_band),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

[sim/haar_2d_wavelet_one_level_tb.sv]
// Self-checking testbench for haar_2d_wavelet_one_level: pixel beats in, band beats out.
// Depends on haar2d_pkg and the RTL top; carries its own bit-exact predictor of the
// transform, a directed table of 2x2 frames and a random part over several image sizes.

module haar_2d_wavelet_one_level_tb;

   localparam int LINE_DEPTH    = 256;
   localparam int MAX_W         = 256;
   localparam int MAX_H         = 256;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int NUM_SEGS      = 8;
   localparam int NUM_DIRECTED  = 7;

   // One band beat as it leaves the block
   typedef struct packed {
      logic [haar2d_pkg::PIX_W-1:0]   coef;
      logic [haar2d_pkg::COORD_W-1:0] row;
      logic [haar2d_pkg::COORD_W-1:0] col;
      logic [1:0]                     band;
      logic                           last;
      logic                           fend;
   } band_beat_type;

   // Directed 2x2 block: pixels, frame start on the first one, typed coefficients
   typedef struct packed {
      logic [haar2d_pkg::PIX_W-1:0] a;
      logic [haar2d_pkg::PIX_W-1:0] b;
      logic [haar2d_pkg::PIX_W-1:0] c;
      logic [haar2d_pkg::PIX_W-1:0] d;
      logic                         fresh;
      logic                         typed;
      logic [haar2d_pkg::PIX_W-1:0] ll;
      logic [haar2d_pkg::PIX_W-1:0] hl;
      logic [haar2d_pkg::PIX_W-1:0] lh;
      logic [haar2d_pkg::PIX_W-1:0] hh;
   } corner_case_type;

   // DUT ports
   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_push        = 1'b0;
   logic                             req_full;
   logic [haar2d_pkg::PIX_W-1:0]     req_pixel       = '0;
   logic                             req_frame_start = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop         = 1'b0;
   logic [haar2d_pkg::PIX_W-1:0]     rsp_coefficient;
   logic [haar2d_pkg::COORD_W-1:0]   rsp_out_row;
   logic [haar2d_pkg::COORD_W-1:0]   rsp_out_col;
   logic [1:0]                       rsp_band;
   logic                             rsp_last_of_block;
   logic                             rsp_frame_end;
   logic                             csr_psel        = 1'b0;
   logic                             csr_penable     = 1'b0;
   logic                             csr_pwrite      = 1'b0;
   logic [2:0]                       csr_paddr       = '0;
   logic [31:0]                      csr_pwdata      = '0;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   // Predictor state
   logic [haar2d_pkg::PIX_W-1:0]     line_store   [LINE_DEPTH];
   bit                               line_written [LINE_DEPTH];
   logic [haar2d_pkg::PIX_W-1:0]     left_pixel;
   int                               col_pos;
   int                               row_pos;
   logic [haar2d_pkg::CFG_W-1:0]     width_reg;
   logic [haar2d_pkg::CFG_W-1:0]     height_reg;
   band_beat_type                    band_queue [$];

   // Typed expectations for the directed beat now on the request port
   bit                               typed_valid = 1'b0;
   band_beat_type                    typed_beats [4];
   band_beat_type                    directed_beats [4];

   // Run bookkeeping
   int                  cycle_count   = 0;
   int                  mismatches    = 0;
   int                  beats_checked = 0;
   int                  pixels_taken  = 0;
   int                  frames_closed = 0;
   int                  sender_gap_pct   = 0;
   int                  receiver_stall_pct = 0;

   corner_case_type     directed_rows [NUM_DIRECTED];

   // Random segments: size writes, item count, fresh frame, frame-start noise in percent
   int seg_w     [NUM_SEGS] = '{2, 7, 0, 10, 2, 12, 511, 6};
   int seg_h     [NUM_SEGS] = '{2, 4, 9, 6, 256, 1, 3, 300};
   int seg_items [NUM_SEGS] = '{8, 12, 8, 16, 8, 16, 272, 8};
   int seg_fresh [NUM_SEGS] = '{1, 0, 0, 1, 1, 0, 1, 0};
   int seg_noise [NUM_SEGS] = '{2, 2, 3, 2, 1, 3, 0, 2};

   haar_2d_wavelet_one_level dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_coefficient   (rsp_coefficient),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_band          (rsp_band),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_frame_end     (rsp_frame_end),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Size in use: low bit dropped, saturated to 2..max
   function automatic int eff_size(input logic [haar2d_pkg::CFG_W-1:0] r, input int maxv);
      int v;
      int m;
      v = int'(r) & ~1;
      m = maxv & ~1;
      if (v < 2) v = 2;
      if (v > m) v = m;
      return v;
   endfunction

   // Divide by 2^sh, round half to even, clamp to 0..255
   function automatic logic [haar2d_pkg::PIX_W-1:0] scale_round(input int s, input int sh);
      int q;
      int r;
      int half;
      if (s <= 0) return '0;
      q    = s >> sh;
      r    = s & ((1 << sh) - 1);
      half = (sh == 0) ? 1 : (1 << (sh - 1));
      if (sh != 0 && (r > half || (r == half && q[0]))) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // Position the next pixel lands on, after frame start and size restarts
   function automatic void place_pixel(input bit fs, output int c, output int r);
      int w;
      int h;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      c = fs ? 0 : col_pos;
      r = fs ? 0 : row_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
   endfunction

   // True when this pixel would close a block over a line-store entry never written
   function automatic bit reads_unwritten(input bit fs);
      int c;
      int r;
      place_pixel(fs, c, r);
      return (r % 2 == 1) && (c % 2 == 1) && !(line_written[c-1] && line_written[c]);
   endfunction

   // Take one pixel, return the band beats it completes
   task automatic haar_step(input logic [haar2d_pkg::PIX_W-1:0] px, input bit fs,
                            output band_beat_type res [4], output int n);
      int w, h, c, r;
      int pa, pb, pc, pd;
      int r0, c0, r1, c1;
      logic fend;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      place_pixel(fs, c, r);
      n = 0;
      if (r % 2 == 0) begin
         line_store[c]   = px;
         line_written[c] = 1'b1;
      end else if (c % 2 == 0) begin
         left_pixel = px;
      end else begin
         pa   = int'(line_store[c-1]);
         pb   = int'(line_store[c]);
         pc   = int'(left_pixel);
         pd   = int'(px);
         r0   = r / 2;
         c0   = c / 2;
         r1   = r0 + h / 2;
         c1   = c0 + w / 2;
         fend = (r == h - 1) && (c == w - 1);
         res[0] = '{scale_round(pa + pb + pc + pd, 2), r0[7:0], c0[7:0],
                    haar2d_pkg::BAND_LL, 1'b0, 1'b0};
         res[1] = '{scale_round(pa - pb + pc - pd, 1), r0[7:0], c1[7:0],
                    haar2d_pkg::BAND_HL, 1'b0, 1'b0};
         res[2] = '{scale_round(pa + pb - pc - pd, 1), r1[7:0], c0[7:0],
                    haar2d_pkg::BAND_LH, 1'b0, 1'b0};
         res[3] = '{scale_round(pa - pb - pc + pd, 0), r1[7:0], c1[7:0],
                    haar2d_pkg::BAND_HH, 1'b1, fend};
         n = 4;
      end
      // advance raster position
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("tb: %s mismatch at beat %0d: got %0d, expected %0d",
               what, beats_checked, got, want);
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // Compare result beats, predict on accepted pixel beats, watch the cycle limit
   always @(posedge clock) begin : monitor
      band_beat_type got;
      band_beat_type want;
      band_beat_type res [4];
      int            n;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_coefficient, rsp_out_row, rsp_out_col, rsp_band,
                    rsp_last_of_block, rsp_frame_end};
            if (band_queue.size() == 0) begin
               report_mismatch("unexpected beat, coefficient", int'(got.coef), -1);
            end else begin
               want = band_queue.pop_front();
               check_field("coefficient",   int'(got.coef), int'(want.coef));
               check_field("out_row",       int'(got.row),  int'(want.row));
               check_field("out_col",       int'(got.col),  int'(want.col));
               check_field("band",          int'(got.band), int'(want.band));
               check_field("last_of_block", int'(got.last), int'(want.last));
               check_field("frame_end",     int'(got.fend), int'(want.fend));
               if (want.fend) frames_closed++;
            end
            beats_checked++;
         end
         if (req_push && !req_full) begin
            haar_step(req_pixel, req_frame_start, res, n);
            if (typed_valid) begin
               foreach (typed_beats[i]) band_queue.push_back(typed_beats[i]);
            end else begin
               for (int i = 0; i < n; i++) band_queue.push_back(res[i]);
            end
            pixels_taken++;
         end
      end
   end

   // Result side: random stalls, decided at the falling edge
   always @(negedge clock) begin
      rsp_pop <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------- drivers

   // Present one pixel beat and hold it until taken
   task automatic send_pixel(input logic [haar2d_pkg::PIX_W-1:0] px, input bit fs,
                             input bit typed);
      bit start;
      @(negedge clock);
      while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      // never close a block over line-store entries nobody wrote
      start = fs || reads_unwritten(fs);
      typed_valid = typed;
      if (typed) typed_beats = directed_beats;
      req_push        <= 1'b1;
      req_pixel       <= px;
      req_frame_start <= start;
      do @(posedge clock); while (req_full);
   endtask

   // Stop sending, wait for every expected beat, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (band_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == haar2d_pkg::REG_WIDTH) width_reg = value[haar2d_pkg::CFG_W-1:0];
      else height_reg = value[haar2d_pkg::CFG_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(input logic idx, output logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write both sizes with junk in the upper bits, read each back
   task automatic apply_size(input int w, input int h);
      logic [31:0] wv;
      logic [31:0] hv;
      logic [31:0] rd;
      wv = ($urandom & 32'hFFFF_FE00) | 32'(w);
      hv = ($urandom & 32'hFFFF_FE00) | 32'(h);
      csr_write(haar2d_pkg::REG_WIDTH, wv);
      csr_read(haar2d_pkg::REG_WIDTH, rd);
      check_field("image_width readback", int'(rd[haar2d_pkg::CFG_W-1:0]),
                  int'(wv[haar2d_pkg::CFG_W-1:0]));
      csr_write(haar2d_pkg::REG_HEIGHT, hv);
      csr_read(haar2d_pkg::REG_HEIGHT, rd);
      check_field("image_height readback", int'(rd[haar2d_pkg::CFG_W-1:0]),
                  int'(hv[haar2d_pkg::CFG_W-1:0]));
   endtask

   // Pixels biased toward both ends to hit ties and clamps
   function automatic logic [haar2d_pkg::PIX_W-1:0] random_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return 8'($urandom_range(3));
      else if (pick < 30) return 8'(252 + $urandom_range(3));
      else return 8'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [31:0]                  rd;
      logic [haar2d_pkg::PIX_W-1:0] quad [4];
      corner_case_type              row;
      bit                           fs;

      // predictor after reset; line store stays unknown until written
      left_pixel = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = haar2d_pkg::SIZE_RESET;
      height_reg = haar2d_pkg::SIZE_RESET;
      foreach (line_written[i]) line_written[i] = 1'b0;

      // 2x2 frames: every block is a whole frame, coordinates are fixed
      directed_rows[0] = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
                           8'd255, 8'd0,   8'd0,   8'd0};
      directed_rows[1] = '{8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 1'b1,
                           8'd128, 8'd255, 8'd0,   8'd0};
      directed_rows[2] = '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 1'b1,
                           8'd128, 8'd0,   8'd0,   8'd255};
      directed_rows[3] = '{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 1'b1,
                           8'd128, 8'd0,   8'd255, 8'd0};
      directed_rows[4] = '{8'd1,   8'd0,   8'd1,   8'd0,   1'b0, 1'b1,
                           8'd0,   8'd1,   8'd0,   8'd0};
      directed_rows[5] = '{8'd5,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1,
                           8'd1,   8'd2,   8'd2,   8'd5};
      directed_rows[6] = '{8'd90,  8'd200, 8'd7,   8'd33,  1'b0, 1'b0,
                           8'd0,   8'd0,   8'd0,   8'd0};

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // size registers out of reset
      csr_read(haar2d_pkg::REG_WIDTH, rd);
      check_field("image_width after reset", int'(rd[haar2d_pkg::CFG_W-1:0]),
                  int'(haar2d_pkg::SIZE_RESET));
      csr_read(haar2d_pkg::REG_HEIGHT, rd);
      check_field("image_height after reset", int'(rd[haar2d_pkg::CFG_W-1:0]),
                  int'(haar2d_pkg::SIZE_RESET));

      // first idling mix: sender light, receiver heavy
      sender_gap_pct     = 23;
      receiver_stall_pct = 46;

      // directed table at the smallest size
      apply_size(2, 2);
      foreach (directed_rows[r]) begin
         row  = directed_rows[r];
         quad = '{row.a, row.b, row.c, row.d};
         directed_beats[0] = '{row.ll, 8'd0, 8'd0, haar2d_pkg::BAND_LL, 1'b0, 1'b0};
         directed_beats[1] = '{row.hl, 8'd0, 8'd1, haar2d_pkg::BAND_HL, 1'b0, 1'b0};
         directed_beats[2] = '{row.lh, 8'd1, 8'd0, haar2d_pkg::BAND_LH, 1'b0, 1'b0};
         directed_beats[3] = '{row.hh, 8'd1, 8'd1, haar2d_pkg::BAND_HH, 1'b1, 1'b1};
         for (int k = 0; k < 4; k++) begin
            send_pixel(quad[k], row.fresh && k == 0, row.typed && k == 3);
         end
      end
      drain_results();

      // random raster streams over a range of sizes
      for (int s = 0; s < NUM_SEGS; s++) begin
         if (s == 3) begin
            sender_gap_pct     = 46;
            receiver_stall_pct = 23;
         end else if (s == 6) begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         apply_size(seg_w[s], seg_h[s]);
         for (int k = 0; k < seg_items[s]; k++) begin
            // one full hold-off mid-stream until every beat is out
            if (s == 3 && k == 8) drain_results();
            fs = (k == 0 && seg_fresh[s] != 0) || ($urandom_range(99) < seg_noise[s]);
            send_pixel(random_pixel(), fs, 1'b0);
         end
         drain_results();
      end

      $display("tb: %0d pixel beats in, %0d band beats checked, %0d frames closed",
               pixels_taken, beats_checked, frames_closed);
      $display("tb: sizes 2x2 to 256 wide and 256 tall, odd and out-of-range writes, %0s",
               "three idling mixes");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/haar2d_pkg.sv
hw/rtl/haar2d_front.sv
hw/rtl/haar2d_queue.sv
hw/rtl/haar2d_back.sv
hw/rtl/haar_2d_wavelet_one_level.sv
sim/haar_2d_wavelet_one_level_tb.sv
